/* src/cel_pkg.sv */
// ----------------------------------------------------------------------------
// cel_pkg
// Shared constants and types for the compacting entry list.
// ----------------------------------------------------------------------------
package cel_pkg;

   // Field widths of the request and response beats
   localparam int MODE_W  = 2;
   localparam int INDEX_W = 8;
   localparam int VALUE_W = 64;
   localparam int COUNT_W = 9;

   localparam int REQ_FIELDS_W = MODE_W + INDEX_W + VALUE_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = VALUE_W + 1 + COUNT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   // Operation codes
   localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GET    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd3;

   // Result waiting for memory read data
   typedef struct packed {
      logic               use_rd;
      logic               ok;
      logic [COUNT_W-1:0] count;
   } stage_type;

endpackage

/* src/compacting_entry_list.sv */
// ----------------------------------------------------------------------------
// compacting_entry_list
// Ordered list of up to DEPTH values with push, pop, get and delete at index.
// ----------------------------------------------------------------------------
// Push, pop and get are taken one per cycle while the output accepts responses
// and no shift runs; each response passes through the result stage and then
// the output register. Entries live in one RAM with a single read and a single
// write port and registered read data. A successful delete that is not of the
// last entry moves every later entry down one place through that RAM, one entry
// per cycle, and no request beat is taken while it does so. Entries that
// were never pushed are never read, so the RAM needs no clearing after reset.
module compacting_entry_list #(
   parameter int DEPTH      = 256,
   parameter int ITEM_WIDTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // mode[1:0], index[9:2], item_value[73:10], zero pad above
   input  logic [cel_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_value[63:0], ok[64], count[73:65], zero pad above
   output logic [cel_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   import cel_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > INDEX_W + 1) ? CW : INDEX_W + 1;

   localparam logic S_IDLE  = 1'b0;
   localparam logic S_SHIFT = 1'b1;

   // Request fields
   logic [MODE_W-1:0]  req_mode;
   logic [INDEX_W-1:0] req_index;
   logic [VALUE_W-1:0] req_value;

   // Control state
   logic          state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] src_ff, src_in;
   logic [AW-1:0] last_ff, last_in;
   logic          s1_valid_ff, s1_valid_in;
   stage_type     s1_ff, s1_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // Decode and RAM controls
   logic          out_free, s1_adv, accept;
   logic [XW-1:0] count_x, pos_x, pos1_x, last_x;
   logic          op_ok, op_use_rd, op_shift;
   logic [CW-1:0] op_count;
   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [ITEM_WIDTH-1:0] ram_wr_data, ram_rd_data;

   assign req_mode  = req_tdata[MODE_W-1:0];
   assign req_index = req_tdata[MODE_W +: INDEX_W];
   assign req_value = req_tdata[MODE_W + INDEX_W +: VALUE_W];

   // Handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = (state_ff == S_IDLE) && (!s1_valid_ff || out_free);
   assign accept     = req_tvalid && req_tready;

   assign count_x = XW'(count_ff);
   assign pos_x   = XW'(req_index);
   assign pos1_x  = pos_x + XW'(1);
   assign last_x  = count_x - XW'(1);

   // Decode the operation against the current count
   always_comb begin
      op_ok     = 1'b0;
      op_use_rd = 1'b0;
      op_shift  = 1'b0;
      op_count  = count_ff;
      case (req_mode)
         MODE_PUSH: begin
            if (count_x < XW'(DEPTH)) begin
               op_ok    = 1'b1;
               op_count = count_ff + CW'(1);
            end
         end
         MODE_POP: begin
            if (count_ff != '0) begin
               op_ok     = 1'b1;
               op_use_rd = 1'b1;
               op_count  = count_ff - CW'(1);
            end
         end
         MODE_GET: begin
            if (pos_x < count_x) begin
               op_ok     = 1'b1;
               op_use_rd = 1'b1;
            end
         end
         MODE_DELETE: begin
            if (pos_x < count_x) begin
               op_ok    = 1'b1;
               op_count = count_ff - CW'(1);
               op_shift = (pos_x != last_x);
            end
         end
         default: begin
            op_ok = 1'b0;
         end
      endcase
   end

   // Drive the RAM: the shifter owns both ports while it runs
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[AW-1:0];
      ram_wr_data = req_value[ITEM_WIDTH-1:0];
      ram_rd_en   = 1'b0;
      ram_rd_addr = pos_x[AW-1:0];
      if (state_ff == S_SHIFT) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = src_ff - AW'(1);
         ram_wr_data = ram_rd_data;
         ram_rd_en   = (src_ff != last_ff);
         ram_rd_addr = src_ff + AW'(1);
      end else if (accept && op_ok) begin
         case (req_mode)
            MODE_PUSH: begin
               ram_wr_en = 1'b1;
            end
            MODE_POP: begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = last_x[AW-1:0];
            end
            MODE_GET: begin
               ram_rd_en = 1'b1;
            end
            MODE_DELETE: begin
               ram_rd_en   = op_shift;
               ram_rd_addr = pos1_x[AW-1:0];
            end
            default: begin
               ram_rd_en = 1'b0;
            end
         endcase
      end
   end

   // Next state: count, shifter, result stage and output register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      src_in       = src_ff;
      last_in      = last_ff;
      s1_valid_in  = s1_valid_ff;
      s1_in        = s1_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_count_in = rsp_count_ff;

      // Advance the shifter one entry per cycle
      if (state_ff == S_SHIFT) begin
         if (src_ff == last_ff) begin
            state_in = S_IDLE;
         end else begin
            src_in = src_ff + AW'(1);
         end
      end

      // Move the waiting result to the output register
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = s1_ff.use_rd ? VALUE_W'(ram_rd_data) : '0;
         rsp_ok_in    = s1_ff.ok;
         rsp_count_in = s1_ff.count;
         s1_valid_in  = 1'b0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Take a request beat
      if (accept) begin
         count_in     = op_count;
         s1_valid_in  = 1'b1;
         s1_in.use_rd = op_use_rd;
         s1_in.ok     = op_ok;
         s1_in.count  = COUNT_W'(op_count);
         if (req_mode == MODE_DELETE && op_shift) begin
            state_in = S_SHIFT;
            src_in   = pos1_x[AW-1:0];
            last_in  = last_x[AW-1:0];
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      last_ff      <= last_in;
      s1_ff        <= s1_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Entry store
   cel_ram #(
      .WIDTH (ITEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_count_ff, rsp_ok_ff, rsp_value_ff};

endmodule

/* src/cel_ram.sv */
// ----------------------------------------------------------------------------
// cel_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cel_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the compacting entry list.
// ----------------------------------------------------------------------------
// Push, pop, get and delete requests go in as beats from a queue that is
// built before reset. Each accepted request is run through a behavioral
// copy of the list to produce the expected response. Response beats are
// compared field by field against the oldest expected entry. The random
// part runs in phases that grow, shrink, mix or mostly read the list, and
// one phase fills it past capacity. Both sides idle in random bursts. The
// receiver holds off once for a long stretch, and the sender waits for
// the pipeline to drain at the start of each phase.
// ----------------------------------------------------------------------------
module tb_top;
   import cel_pkg::*;

   localparam int LIST_DEPTH     = 256;
   localparam int RANDOM_CMDS    = 1400;
   localparam int QUIET_TAIL     = 150;
   localparam int LONG_HOLD_AT   = 300;
   localparam int LONG_HOLD_LEN  = 80;
   localparam int TAIL_CYCLES    = 20;

   typedef struct {
      logic [MODE_W-1:0]  mode;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] item_value;
      bit                 drain_first;
   } list_cmd_type;

   typedef struct {
      logic [VALUE_W-1:0] read_value;
      logic               ok;
      logic [COUNT_W-1:0] count;
   } list_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   compacting_entry_list #(
      .DEPTH      (LIST_DEPTH),
      .ITEM_WIDTH (VALUE_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Behavioral copy of the list
   logic [VALUE_W-1:0] shadow_entries [LIST_DEPTH];
   int unsigned        shadow_count = 0;

   list_cmd_type    pending_cmds [$];
   list_result_type expected_results [$];
   list_cmd_type    offered;

   int unsigned gen_count = 0;
   int          total_cmds = 0;
   int          quiet_from = 1 << 30;
   int          beats_taken = 0;
   int          results_seen = 0;
   int          mismatch_count = 0;
   int          send_gap = 0;
   int          recv_hold = 0;
   bit          long_hold_done = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one request to the behavioral list and return its response
   function automatic list_result_type apply_list_op(list_cmd_type cmd);
      list_result_type res;
      int unsigned     pos;
      res.read_value = '0;
      res.ok         = 1'b0;
      pos            = cmd.index;
      case (cmd.mode)
         MODE_PUSH: begin
            if (shadow_count < LIST_DEPTH) begin
               shadow_entries[shadow_count] = cmd.item_value;
               shadow_count++;
               res.ok = 1'b1;
            end
         end
         MODE_POP: begin
            if (shadow_count > 0) begin
               res.read_value = shadow_entries[shadow_count - 1];
               shadow_entries[shadow_count - 1] = '0;
               shadow_count--;
               res.ok = 1'b1;
            end
         end
         MODE_GET: begin
            if (pos < shadow_count) begin
               res.read_value = shadow_entries[pos];
               res.ok = 1'b1;
            end
         end
         default: begin
            // delete: close the gap, clear the freed slot at the end
            if (pos < shadow_count) begin
               for (int unsigned k = pos; k + 1 < shadow_count; k++)
                  shadow_entries[k] = shadow_entries[k + 1];
               shadow_entries[shadow_count - 1] = '0;
               shadow_count--;
               res.ok = 1'b1;
            end
         end
      endcase
      res.count = shadow_count[COUNT_W-1:0];
      return res;
   endfunction

   // Queue one request and track the list size for shaping later requests
   function automatic void add_cmd(logic [MODE_W-1:0] mode, int unsigned index,
                                   logic [VALUE_W-1:0] item_value, bit drain_first);
      list_cmd_type cmd;
      cmd.mode        = mode;
      cmd.index       = index[INDEX_W-1:0];
      cmd.item_value  = item_value;
      cmd.drain_first = drain_first;
      pending_cmds.push_back(cmd);
      case (mode)
         MODE_PUSH:   if (gen_count < LIST_DEPTH) gen_count++;
         MODE_POP:    if (gen_count > 0) gen_count--;
         MODE_DELETE: if (index[INDEX_W-1:0] < gen_count) gen_count--;
         default: ;
      endcase
   endfunction

   // Mostly valid positions, some at the boundary, some anywhere
   function automatic int unsigned pick_index();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (gen_count > 0 && r < 7)
         return $urandom_range(0, gen_count - 1);
      else if (r < 8)
         return (gen_count > 255) ? 255 : gen_count;
      else
         return $urandom_range(0, 255);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r == 0)
         return '0;
      else if (r == 1)
         return '1;
      else
         return {$urandom, $urandom};
   endfunction

   task automatic check_result(list_result_type exp_res, logic [RSP_TDATA_W-1:0] beat);
      logic [VALUE_W-1:0] got_value;
      logic               got_ok;
      logic [COUNT_W-1:0] got_count;
      got_value = beat[VALUE_W-1:0];
      got_ok    = beat[VALUE_W];
      got_count = beat[VALUE_W+COUNT_W:VALUE_W+1];
      if (got_value !== exp_res.read_value) begin
         $error("read_value: expected %h, got %h", exp_res.read_value, got_value);
         mismatch_count++;
      end
      if (got_ok !== exp_res.ok) begin
         $error("ok: expected %0d, got %0d", exp_res.ok, got_ok);
         mismatch_count++;
      end
      if (got_count !== exp_res.count) begin
         $error("count: expected %0d, got %0d", exp_res.count, got_count);
         mismatch_count++;
      end
   endtask

   // Request driver: predict on each accepted beat, then offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_list_op(offered));
            beats_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() == 0 ||
                         (pending_cmds[0].drain_first && expected_results.size() != 0)) begin
               // hold until the queue has work, or until the pipeline drains
               req_tvalid <= 1'b0;
            end else if (beats_taken < quiet_from && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(1, 5) - 1;
               req_tvalid <= 1'b0;
            end else begin
               offered = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_TDATA_W'({offered.item_value, offered.index, offered.mode});
            end
         end
      end
   end

   // Response monitor: check each accepted beat, then pick the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected response beat %h", rsp_tdata);
               mismatch_count++;
            end else begin
               check_result(expected_results.pop_front(), rsp_tdata);
            end
            results_seen++;
         end
         if (!long_hold_done && results_seen >= LONG_HOLD_AT && req_tvalid) begin
            // long back-pressure so the block fills and stalls its input
            long_hold_done = 1'b1;
            recv_hold = LONG_HOLD_LEN - 1;
            rsp_tready <= 1'b0;
         end else if (recv_hold != 0) begin
            recv_hold--;
            rsp_tready <= 1'b0;
         end else if (results_seen < quiet_from && $urandom_range(0, 5) == 0) begin
            recv_hold = $urandom_range(1, 5) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int unsigned full_hits;
      int unsigned kind;
      int unsigned phase_len;
      int unsigned r;
      int unsigned p_push;
      int unsigned p_pop;
      int unsigned p_get;
      int          random_start;

      // Directed: empty-list failures, extreme values, ends of the list
      add_cmd(MODE_POP,    0,   '1, 1'b0);
      add_cmd(MODE_GET,    0,   '0, 1'b0);
      add_cmd(MODE_DELETE, 255, '1, 1'b0);
      add_cmd(MODE_PUSH,   255, '1, 1'b0);
      add_cmd(MODE_PUSH,   0,   '0, 1'b0);
      add_cmd(MODE_PUSH,   170, {$urandom, $urandom}, 1'b0);
      add_cmd(MODE_PUSH,   85,  64'h8000_0000_0000_0001, 1'b0);
      add_cmd(MODE_GET,    0,   '0, 1'b0);
      add_cmd(MODE_GET,    4,   '0, 1'b0);
      add_cmd(MODE_GET,    255, '0, 1'b0);
      add_cmd(MODE_GET,    1,   '1, 1'b0);
      add_cmd(MODE_DELETE, 4,   '0, 1'b0);
      add_cmd(MODE_DELETE, 0,   '0, 1'b0);
      add_cmd(MODE_GET,    0,   '0, 1'b0);
      add_cmd(MODE_DELETE, 2,   '0, 1'b0);
      add_cmd(MODE_POP,    0,   '0, 1'b0);
      add_cmd(MODE_POP,    0,   '0, 1'b0);  // zero-valued entry
      add_cmd(MODE_POP,    0,   '0, 1'b0);
      add_cmd(MODE_PUSH,   0,   {$urandom, $urandom}, 1'b0);
      add_cmd(MODE_DELETE, 0,   '0, 1'b0);  // only entry, nothing to shift
      add_cmd(MODE_GET,    0,   '0, 1'b0);

      // Fill to capacity and push against the full list
      random_start = pending_cmds.size();
      full_hits = 0;
      add_cmd(MODE_PUSH, $urandom_range(0, 255), pick_value(), 1'b1);
      while (full_hits < 6) begin
         if ($urandom_range(0, 9) == 0) begin
            add_cmd(MODE_GET, pick_index(), pick_value(), 1'b0);
         end else begin
            if (gen_count == LIST_DEPTH) full_hits++;
            add_cmd(MODE_PUSH, $urandom_range(0, 255), pick_value(), 1'b0);
         end
      end
      add_cmd(MODE_GET,    255, pick_value(), 1'b0);
      add_cmd(MODE_DELETE, 0,   pick_value(), 1'b0);  // longest shift

      // Random phases: grow, shrink, mixed, read-mostly
      while (pending_cmds.size() - random_start < RANDOM_CMDS) begin
         kind      = $urandom_range(0, 3);
         phase_len = $urandom_range(30, 120);
         case (kind)
            0:       begin p_push = 60; p_pop = 70; p_get = 90; end
            1:       begin p_push = 15; p_pop = 55; p_get = 70; end
            2:       begin p_push = 25; p_pop = 50; p_get = 75; end
            default: begin p_push = 20; p_pop = 30; p_get = 90; end
         endcase
         for (int unsigned n = 0; n < phase_len; n++) begin
            r = $urandom_range(0, 99);
            if (r < p_push)
               add_cmd(MODE_PUSH, $urandom_range(0, 255), pick_value(), n == 0);
            else if (r < p_pop)
               add_cmd(MODE_POP, $urandom_range(0, 255), pick_value(), n == 0);
            else if (r < p_get)
               add_cmd(MODE_GET, pick_index(), pick_value(), n == 0);
            else
               add_cmd(MODE_DELETE, pick_index(), pick_value(), n == 0);
         end
      end

      total_cmds = pending_cmds.size();
      quiet_from = total_cmds - QUIET_TAIL;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (beats_taken < total_cmds) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog
   initial begin
      #30_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* filelist.f */
src/cel_pkg.sv
src/cel_ram.sv
src/compacting_entry_list.sv
tb/tb_top.sv
